// ===== rtl/owbm_pkg.sv =====
// Shared types, codes and constants for the one-wire bus master.
package owbm_pkg;

    // Stream widths (tdata in whole bytes)
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int TICK_W = 16;

    // Defaults
    localparam int BITS_PER_BYTE_DEF = 8;
    localparam int QUEUE_DEPTH       = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_TIMEOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOV   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_START    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_HOLD     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_RECOV    = 3'd6;

    // Register reset values
    localparam logic [TICK_W-1:0] RESET_LOW_DEF     = 16'd400;
    localparam logic [BYTE_W-1:0] PRES_TIMEOUT_DEF  = 8'd255;
    localparam logic [TICK_W-1:0] RESET_RECOV_DEF   = 16'd300;
    localparam logic [BYTE_W-1:0] SLOT_START_DEF    = 8'd5;
    localparam logic [BYTE_W-1:0] SLOT_HOLD_DEF     = 8'd50;
    localparam logic [BYTE_W-1:0] READ_LOW_DEF      = 8'd1;
    localparam logic [BYTE_W-1:0] SLOT_RECOV_DEF    = 8'd1;

    // Command codes carried in tuser
    typedef enum logic [1:0] {
        CMD_RESET = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    // Bus sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_REC  = 4'd3,
        PH_W_START  = 4'd4,
        PH_W_HOLD   = 4'd5,
        PH_W_REC    = 4'd6,
        PH_R_LOW    = 4'd7,
        PH_R_HOLD   = 4'd8,
        PH_R_REC    = 4'd9
    } phase_t;

    // Classified input beat
    typedef struct packed {
        cmd_t              cmd;
        logic [BYTE_W-1:0] wdata;
        logic              level;
    } item_t;

    // Timing registers
    typedef struct packed {
        logic [TICK_W-1:0] reset_low;
        logic [BYTE_W-1:0] pres_timeout;
        logic [TICK_W-1:0] reset_recov;
        logic [BYTE_W-1:0] slot_start;
        logic [BYTE_W-1:0] slot_hold;
        logic [BYTE_W-1:0] read_low;
        logic [BYTE_W-1:0] slot_recov;
    } cfg_t;

    // One result beat
    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              presence_seen;
        logic              done_res;
        logic              busy_res;
        logic              drive_low;
    } result_t;

endpackage

// ===== rtl/owbm_front.sv =====
// Input stage: accepts stream beats, classifies them and registers the item.
module owbm_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [owbm_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] write_data, [8] line_level
    input  logic [owbm_pkg::S_TUSER_W-1:0]  s_tuser,   // [1:0] cmd
    output owbm_pkg::item_t                 item,
    output logic                            item_valid,
    input  logic                            item_ready
);
    import owbm_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    logic  accept;

    // Decode the beat into an item
    always_comb
    begin
        item_next.cmd   = cmd_t'(s_tuser);
        item_next.wdata = s_tdata[BYTE_W-1:0];
        item_next.level = s_tdata[BYTE_W];
    end

    assign s_tready = !valid_reg || item_ready;
    assign accept   = s_tvalid && s_tready;

    // Holding register toward the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// ===== rtl/owbm_queue.sv =====
// Short item queue between the input stage and the bus sequencer.
module owbm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  owbm_pkg::item_t in_item,
    input  logic            in_valid,
    output logic            in_ready,
    output owbm_pkg::item_t out_item,
    output logic            out_valid,
    input  logic            out_ready
);
    import owbm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = slot_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/owbm_back.sv =====
// Bus sequencer: runs reset and bit slots on time ticks, registers one result per item.
module owbm_back #(
    parameter int BITS_PER_BYTE = owbm_pkg::BITS_PER_BYTE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  owbm_pkg::cfg_t                  cfg,
    input  owbm_pkg::item_t                 item,
    input  logic                            item_valid,
    output logic                            item_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [owbm_pkg::M_TDATA_W-1:0]  m_tdata
);
    import owbm_pkg::*;

    localparam int BL_W = $clog2(BITS_PER_BYTE + 1);

    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [BL_W-1:0]   bits_reg, bits_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic              presence_reg, presence_next;
    logic              op_read_reg, op_read_next;
    logic [BYTE_W-1:0] last_read_reg, last_read_next;
    logic              done_next;
    logic              mvalid_reg;
    result_t           result_reg, result_next;

    logic [TICK_W-1:0] len;
    logic [TICK_W-1:0] count_inc;
    logic              ends;
    logic [TICK_W-1:0] tick_adv;
    logic [BL_W-1:0]   bits_dec;
    logic              pop;

    assign item_ready = !mvalid_reg || m_tready;
    assign pop        = item_valid && item_ready;

    // Phase length select and shared tick counter compare
    always_comb
    begin
        unique case (phase_reg)
            PH_RST_LOW:             len = cfg.reset_low;
            PH_RST_WAIT:            len = TICK_W'(cfg.pres_timeout);
            PH_RST_REC:             len = cfg.reset_recov;
            PH_W_START:             len = TICK_W'(cfg.slot_start);
            PH_W_HOLD, PH_R_HOLD:   len = TICK_W'(cfg.slot_hold);
            PH_R_LOW:               len = TICK_W'(cfg.read_low);
            PH_W_REC, PH_R_REC:     len = TICK_W'(cfg.slot_recov);
            default:                len = TICK_W'(1);
        endcase
    end

    assign count_inc = tick_reg + 1'b1;
    assign ends      = (count_inc >= len);
    assign tick_adv  = ends ? '0 : count_inc;
    assign bits_dec  = (bits_reg != '0) ? bits_reg - 1'b1 : bits_reg;

    // Next state
    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bits_next      = bits_reg;
        shift_next     = shift_reg;
        presence_next  = presence_reg;
        op_read_next   = op_read_reg;
        last_read_next = last_read_reg;
        done_next      = 1'b0;

        if (item.cmd != CMD_TICK)
        begin
            // Commands start only from idle
            if (phase_reg == PH_IDLE)
            begin
                tick_next = '0;
                unique case (item.cmd)
                    CMD_RESET:
                    begin
                        presence_next = 1'b0;
                        phase_next    = PH_RST_LOW;
                    end
                    CMD_WRITE:
                    begin
                        op_read_next = 1'b0;
                        shift_next   = item.wdata;
                        bits_next    = BL_W'(BITS_PER_BYTE);
                        phase_next   = PH_W_START;
                    end
                    default:
                    begin
                        op_read_next = 1'b1;
                        shift_next   = '0;
                        bits_next    = BL_W'(BITS_PER_BYTE);
                        phase_next   = PH_R_LOW;
                    end
                endcase
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_RST_LOW:
                begin
                    tick_next = tick_adv;
                    if (ends)
                    begin
                        phase_next = PH_RST_WAIT;
                    end
                end
                PH_RST_WAIT:
                begin
                    if (!item.level)
                    begin
                        presence_next = 1'b1;
                        tick_next     = '0;
                        phase_next    = PH_RST_REC;
                    end
                    else
                    begin
                        tick_next = tick_adv;
                        if (ends)
                        begin
                            phase_next = PH_RST_REC;
                        end
                    end
                end
                PH_RST_REC:
                begin
                    tick_next = tick_adv;
                    if (ends)
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
                PH_W_START:
                begin
                    tick_next = tick_adv;
                    if (ends)
                    begin
                        phase_next = PH_W_HOLD;
                    end
                end
                PH_W_HOLD:
                begin
                    tick_next = tick_adv;
                    if (ends)
                    begin
                        phase_next = PH_W_REC;
                    end
                end
                PH_R_LOW:
                begin
                    tick_next = tick_adv;
                    if (ends)
                    begin
                        phase_next = PH_R_HOLD;
                    end
                end
                PH_R_HOLD:
                begin
                    // Sample on the first released tick, shifted in at the MSB
                    if (tick_reg == '0)
                    begin
                        shift_next = {item.level, shift_reg[BYTE_W-1:1]};
                    end
                    tick_next = tick_adv;
                    if (ends)
                    begin
                        phase_next = PH_R_REC;
                    end
                end
                PH_W_REC, PH_R_REC:
                begin
                    tick_next = tick_adv;
                    if (ends)
                    begin
                        if (phase_reg == PH_W_REC)
                        begin
                            shift_next = {1'b0, shift_reg[BYTE_W-1:1]};
                        end
                        // Slot closed: next bit or byte complete
                        bits_next = bits_dec;
                        if (bits_dec == '0)
                        begin
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                            if (op_read_reg)
                            begin
                                last_read_next = shift_next;
                            end
                        end
                        else
                        begin
                            phase_next = op_read_reg ? PH_R_LOW : PH_W_START;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            endcase
        end
    end

    // Result for the state after this item
    always_comb
    begin
        unique case (phase_next)
            PH_RST_LOW, PH_W_START, PH_R_LOW: result_next.drive_low = 1'b1;
            PH_W_HOLD:                        result_next.drive_low = !shift_next[0];
            default:                          result_next.drive_low = 1'b0;
        endcase
        result_next.busy_res      = (phase_next != PH_IDLE);
        result_next.done_res      = done_next;
        result_next.presence_seen = presence_next;
        result_next.read_data     = last_read_next;
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bits_reg      <= '0;
            shift_reg     <= '0;
            presence_reg  <= 1'b0;
            op_read_reg   <= 1'b0;
            last_read_reg <= '0;
        end
        else if (pop)
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bits_reg      <= bits_next;
            shift_reg     <= shift_next;
            presence_reg  <= presence_next;
            op_read_reg   <= op_read_next;
            last_read_reg <= last_read_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvalid_reg <= 1'b0;
        end
        else if (pop)
        begin
            mvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = M_TDATA_W'(result_reg);

endmodule

// ===== rtl/one_wire_bus_master.sv =====
// One-wire bus master: an input stage and a bus sequencer joined by a short
// queue. Every input beat (reset, write byte, read byte, or a time tick that
// carries the sampled bus level) yields one output beat with the line drive,
// busy, done, presence and last read byte as they stand after that beat. One
// beat is taken per clock cycle unless the output stalls; the phase counter
// does one tick compare per beat. A result passes the input register, the
// queue and the output register. Timing registers must be written through the
// cfg port only while the master is idle; the block does not enforce this.
module one_wire_bus_master #(
    parameter int BITS_PER_BYTE = owbm_pkg::BITS_PER_BYTE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [owbm_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] write_data, [8] line_level
    input  logic [owbm_pkg::S_TUSER_W-1:0]   s_tuser,   // [1:0] cmd
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [owbm_pkg::M_TDATA_W-1:0]   m_tdata,   // [0] drive_low, [1] busy_res,
                                                        // [2] done_res, [3] presence_seen,
                                                        // [11:4] read_data
    input  logic                             cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import owbm_pkg::*;

    cfg_t  cfg_reg;
    item_t fr_item;
    logic  fr_valid;
    logic  fr_ready;
    item_t q_item;
    logic  q_valid;
    logic  q_ready;

    // Timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low    <= RESET_LOW_DEF;
            cfg_reg.pres_timeout <= PRES_TIMEOUT_DEF;
            cfg_reg.reset_recov  <= RESET_RECOV_DEF;
            cfg_reg.slot_start   <= SLOT_START_DEF;
            cfg_reg.slot_hold    <= SLOT_HOLD_DEF;
            cfg_reg.read_low     <= READ_LOW_DEF;
            cfg_reg.slot_recov   <= SLOT_RECOV_DEF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RESET_LOW:    cfg_reg.reset_low    <= cfg_data;
                REG_PRES_TIMEOUT: cfg_reg.pres_timeout <= cfg_data[BYTE_W-1:0];
                REG_RESET_RECOV:  cfg_reg.reset_recov  <= cfg_data;
                REG_SLOT_START:   cfg_reg.slot_start   <= cfg_data[BYTE_W-1:0];
                REG_SLOT_HOLD:    cfg_reg.slot_hold    <= cfg_data[BYTE_W-1:0];
                REG_READ_LOW:     cfg_reg.read_low     <= cfg_data[BYTE_W-1:0];
                REG_SLOT_RECOV:   cfg_reg.slot_recov   <= cfg_data[BYTE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    owbm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item       (fr_item),
        .item_valid (fr_valid),
        .item_ready (fr_ready)
    );

    owbm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (fr_item),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .out_item  (q_item),
        .out_valid (q_valid),
        .out_ready (q_ready)
    );

    owbm_back #(
        .BITS_PER_BYTE (BITS_PER_BYTE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (q_item),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

`ifndef SYNTHESIS
    // An item taken by the sequencer shows up as a result beat next cycle
    a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |=> m_tvalid)
        else $error("sequencer consumed an item without producing a result");

    // The input stalls only when the queue is full
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (fr_valid && !fr_ready))
        else $error("input stalled while the queue had room");

    // The line is pulled low only during an operation
    a_drive_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> m_tdata[1])
        else $error("line driven low while idle");

    // Completion leaves the master idle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2]) |-> !m_tdata[1])
        else $error("done reported while still busy");
`endif

endmodule

// ===== tb/tb_one_wire_bus_master.sv =====
// Self-checking stream testbench for the one-wire bus master.
`timescale 1ns / 100ps

module tb_one_wire_bus_master;
    import owbm_pkg::*;

    localparam int CLK_HALF               = 10;
    localparam int RESET_CYCLES           = 7;
    localparam int BYTE_BITS              = BITS_PER_BYTE_DEF;
    localparam int WATCHDOG_LIMIT         = 4000;
    localparam int DRAIN_CYCLES           = 8;
    localparam int RANDOM_ITEMS_PER_PHASE = 110;
    localparam int ITEMS_PER_SETTING      = 55;
    localparam int SETTLE_CHUNK           = 16;

    // bus level pattern carried by a run of ticks
    typedef enum int {
        LVL_RANDOM,
        LVL_HIGH,
        LVL_LOW
    } level_mode_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [7:0] write_data, [8] line_level
    logic [S_TUSER_W-1:0]  s_tuser   = '0;   // [1:0] cmd
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [0] drive_low, [1] busy_res, [2] done_res,
                                             // [3] presence_seen, [11:4] read_data
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // stimulus and scoreboard
    item_t       beats_to_send[$];
    result_t     bus_status_due[$];
    item_t       next_beat;
    result_t     want_status;
    result_t     got_status;
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_count     = 0;
    int unsigned quiet_cycles   = 0;

    // predicted sequencer state and timing
    cfg_t              bus_cfg   = {RESET_LOW_DEF, PRES_TIMEOUT_DEF, RESET_RECOV_DEF,
                                    SLOT_START_DEF, SLOT_HOLD_DEF, READ_LOW_DEF,
                                    SLOT_RECOV_DEF};
    phase_t            bus_ph    = PH_IDLE;
    logic [TICK_W-1:0] tick_cnt  = '0;
    int unsigned       bits_left = 0;
    logic [BYTE_W-1:0] shift_reg = '0;
    logic              presence  = 1'b0;
    logic              is_read   = 1'b0;
    logic [BYTE_W-1:0] last_byte = '0;

    always #(CLK_HALF) clk = ~clk;

    one_wire_bus_master dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // one tick of a timed phase; true once the phase has run len ticks
    function automatic bit tick_done(input logic [TICK_W-1:0] len);
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= len)
        begin
            tick_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // end of a bit slot; true when the whole byte is through
    function automatic bit close_slot();
        if (bits_left > 0)
            bits_left--;
        if (bits_left == 0)
        begin
            bus_ph = PH_IDLE;
            if (is_read)
                last_byte = shift_reg;
            return 1'b1;
        end
        bus_ph = is_read ? PH_R_LOW : PH_W_START;
        return 1'b0;
    endfunction

    // apply one beat to the predicted sequencer, return the status after it
    function automatic result_t advance_bus(input cmd_t c, input logic [BYTE_W-1:0] wd,
                                            input logic lvl);
        result_t r;
        bit      fin;
        fin = 1'b0;
        if (c != CMD_TICK)
        begin
            // commands start only from idle; a command never advances time
            if (bus_ph == PH_IDLE)
            begin
                tick_cnt = '0;
                case (c)
                    CMD_RESET:
                    begin
                        presence = 1'b0;
                        bus_ph   = PH_RST_LOW;
                    end
                    CMD_WRITE:
                    begin
                        is_read   = 1'b0;
                        shift_reg = wd;
                        bits_left = BYTE_BITS;
                        bus_ph    = PH_W_START;
                    end
                    default:
                    begin
                        is_read   = 1'b1;
                        shift_reg = '0;
                        bits_left = BYTE_BITS;
                        bus_ph    = PH_R_LOW;
                    end
                endcase
            end
        end
        else
        begin
            case (bus_ph)
                PH_RST_LOW:
                    if (tick_done(bus_cfg.reset_low))
                        bus_ph = PH_RST_WAIT;
                PH_RST_WAIT:
                begin
                    // low line is the presence answer, else count toward timeout
                    if (!lvl)
                    begin
                        presence = 1'b1;
                        tick_cnt = '0;
                        bus_ph   = PH_RST_REC;
                    end
                    else if (tick_done(TICK_W'(bus_cfg.pres_timeout)))
                        bus_ph = PH_RST_REC;
                end
                PH_RST_REC:
                    if (tick_done(bus_cfg.reset_recov))
                    begin
                        bus_ph = PH_IDLE;
                        fin    = 1'b1;
                    end
                PH_W_START:
                    if (tick_done(TICK_W'(bus_cfg.slot_start)))
                        bus_ph = PH_W_HOLD;
                PH_W_HOLD:
                    if (tick_done(TICK_W'(bus_cfg.slot_hold)))
                        bus_ph = PH_W_REC;
                PH_W_REC:
                    if (tick_done(TICK_W'(bus_cfg.slot_recov)))
                    begin
                        shift_reg = shift_reg >> 1;
                        fin       = close_slot();
                    end
                PH_R_LOW:
                    if (tick_done(TICK_W'(bus_cfg.read_low)))
                        bus_ph = PH_R_HOLD;
                PH_R_HOLD:
                begin
                    // sample on the first released tick, shift in from the top
                    if (tick_cnt == '0)
                        shift_reg = {lvl, shift_reg[BYTE_W-1:1]};
                    if (tick_done(TICK_W'(bus_cfg.slot_hold)))
                        bus_ph = PH_R_REC;
                end
                PH_R_REC:
                    if (tick_done(TICK_W'(bus_cfg.slot_recov)))
                        fin = close_slot();
                default:
                begin
                    bus_ph   = PH_IDLE;
                    tick_cnt = '0;
                end
            endcase
        end

        case (bus_ph)
            PH_RST_LOW, PH_W_START, PH_R_LOW: r.drive_low = 1'b1;
            PH_W_HOLD:                        r.drive_low = ~shift_reg[0];
            default:                          r.drive_low = 1'b0;
        endcase
        r.busy_res      = (bus_ph != PH_IDLE);
        r.done_res      = fin;
        r.presence_seen = presence;
        r.read_data     = last_byte;
        return r;
    endfunction

    // ticks a command takes at the current timing (reset: no presence answer)
    function automatic int unsigned op_ticks(input cmd_t c);
        case (c)
            CMD_RESET:
                return int'(bus_cfg.reset_low) + int'(bus_cfg.pres_timeout) +
                       int'(bus_cfg.reset_recov);
            CMD_WRITE:
                return BYTE_BITS * (int'(bus_cfg.slot_start) + int'(bus_cfg.slot_hold) +
                                    int'(bus_cfg.slot_recov));
            CMD_READ:
                return BYTE_BITS * (int'(bus_cfg.read_low) + int'(bus_cfg.slot_hold) +
                                    int'(bus_cfg.slot_recov));
            default:
                return 0;
        endcase
    endfunction

    function automatic void queue_beat(input cmd_t c, input logic [BYTE_W-1:0] wd,
                                       input logic lvl);
        item_t it;
        it.cmd   = c;
        it.wdata = wd;
        it.level = lvl;
        beats_to_send.push_back(it);
    endfunction

    function automatic void queue_ticks(input int unsigned n, input level_mode_t mode);
        logic lvl;
        for (int unsigned i = 0; i < n; i++)
        begin
            case (mode)
                LVL_HIGH: lvl = 1'b1;
                LVL_LOW:  lvl = 1'b0;
                default:  lvl = 1'($urandom_range(1));
            endcase
            queue_beat(CMD_TICK, BYTE_W'($urandom_range(255)), lvl);
        end
    endfunction

    // command followed by the ticks it needs plus a few idle ones
    function automatic void queue_op(input cmd_t c, input logic [BYTE_W-1:0] wd,
                                     input level_mode_t mode);
        queue_beat(c, wd, 1'($urandom_range(1)));
        queue_ticks(op_ticks(c) + 2, mode);
    endfunction

    function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                        input logic [BYTE_W-1:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_RESET_LOW:    bus_cfg.reset_low    = val[TICK_W-1:0];
            REG_PRES_TIMEOUT: bus_cfg.pres_timeout = val[BYTE_W-1:0];
            REG_RESET_RECOV:  bus_cfg.reset_recov  = val[TICK_W-1:0];
            REG_SLOT_START:   bus_cfg.slot_start   = val[BYTE_W-1:0];
            REG_SLOT_HOLD:    bus_cfg.slot_hold    = val[BYTE_W-1:0];
            REG_READ_LOW:     bus_cfg.read_low     = val[BYTE_W-1:0];
            REG_SLOT_RECOV:   bus_cfg.slot_recov   = val[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_timing(input int unsigned rst_low, input int unsigned pres_to,
                              input int unsigned rst_rec, input int unsigned slot_st,
                              input int unsigned slot_hd, input int unsigned rd_low,
                              input int unsigned slot_rc);
        write_reg(REG_RESET_LOW, rst_low);
        write_reg(REG_PRES_TIMEOUT, pres_to);
        write_reg(REG_RESET_RECOV, rst_rec);
        write_reg(REG_SLOT_START, slot_st);
        write_reg(REG_SLOT_HOLD, slot_hd);
        write_reg(REG_READ_LOW, rd_low);
        write_reg(REG_SLOT_RECOV, slot_rc);
    endtask

    // wait until every queued beat is sent and every result checked;
    // sampled on the falling edge so the driver's rising-edge updates have landed
    task automatic drain();
        @(negedge clk);
        while (beats_to_send.size() != 0 || s_tvalid || bus_status_due.size() != 0)
            @(negedge clk);
    endtask

    // drain all beats and results, tick the sequencer back to idle, then pause
    task automatic settle();
        forever
        begin
            drain();
            if (bus_ph == PH_IDLE)
                break;
            queue_ticks(SETTLE_CHUNK, LVL_RANDOM);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // start an operation under the longest timing, then shorten it mid-phase
    task automatic cut_long_op(input cmd_t c, input logic [BYTE_W-1:0] wd);
        set_timing(65535, 255, 65535, 255, 255, 255, 255);
        queue_beat(c, wd, 1'b1);
        queue_ticks(SETTLE_CHUNK, LVL_HIGH);
        drain();
        set_timing(1, 1, 1, 1, 1, 1, 1);
        settle();
    endtask

    // random operations with random content under one idling pattern
    task automatic random_phase(input int unsigned gap_pct, input int unsigned stall_pct);
        int unsigned phase_items;
        int unsigned setting_items;
        int unsigned full_len;
        int unsigned cut_len;
        cmd_t        op;
        level_mode_t mode;
        phase_items    = 0;
        setting_items  = ITEMS_PER_SETTING;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        while (phase_items < RANDOM_ITEMS_PER_PHASE)
        begin
            // fresh short timing once the bus is quiet
            if (setting_items >= ITEMS_PER_SETTING)
            begin
                settle();
                set_timing($urandom_range(1, 12), $urandom_range(1, 12),
                           $urandom_range(1, 12), $urandom_range(1, 3),
                           $urandom_range(1, 3), $urandom_range(1, 3),
                           $urandom_range(1, 3));
                setting_items = 0;
            end
            if ($urandom_range(9) == 0)
            begin
                // stray beats: any command, any data
                repeat ($urandom_range(1, 4))
                    queue_beat(cmd_t'($urandom_range(int'(CMD_TICK))),
                               BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
            end
            else
            begin
                op       = cmd_t'($urandom_range(int'(CMD_READ)));
                mode     = level_mode_t'($urandom_range(int'(LVL_LOW)));
                full_len = op_ticks(op);
                cut_len  = ($urandom_range(7) == 0) ? $urandom_range(full_len) : full_len;
                queue_beat(op, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
                queue_ticks(cut_len, mode);
                if (cut_len < full_len)
                begin
                    // command landing mid-operation
                    queue_beat(cmd_t'($urandom_range(int'(CMD_READ))),
                               BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
                    queue_ticks(full_len - cut_len, mode);
                end
                queue_ticks($urandom_range(2), mode);
                phase_items   += full_len + 1;
                setting_items += full_len + 1;
            end
        end
        settle();
    endtask

    // input driver: hold a beat until taken, random gaps between beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                bus_status_due.push_back(advance_bus(cmd_t'(s_tuser), s_tdata[BYTE_W-1:0],
                                                     s_tdata[BYTE_W]));
            if (!s_tvalid || s_tready)
            begin
                if (beats_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    next_beat = beats_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({next_beat.level, next_beat.wdata});
                    s_tuser  <= next_beat.cmd;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // output monitor: random backpressure, compare each beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready)
            begin
                got_status = m_tdata[$bits(result_t)-1:0];
                if (bus_status_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected beat, expected none, got %0h", $time, m_tdata);
                end
                else
                begin
                    want_status = bus_status_due.pop_front();
                    check_field("drive_low", BYTE_W'(want_status.drive_low),
                                BYTE_W'(got_status.drive_low));
                    check_field("busy_res", BYTE_W'(want_status.busy_res),
                                BYTE_W'(got_status.busy_res));
                    check_field("done_res", BYTE_W'(want_status.done_res),
                                BYTE_W'(got_status.done_res));
                    check_field("presence_seen", BYTE_W'(want_status.presence_seen),
                                BYTE_W'(got_status.presence_seen));
                    check_field("read_data", want_status.read_data, got_status.read_data);
                end
            end
        end
    end

    // watchdog: no beat moving on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // timing at reset values: idle ticks, then a reset answered right after the pulse
        queue_beat(CMD_TICK, 8'h00, 1'b0);
        queue_beat(CMD_TICK, 8'hFF, 1'b1);
        queue_beat(CMD_RESET, 8'h00, 1'b1);
        queue_ticks(int'(RESET_LOW_DEF), LVL_RANDOM);
        queue_ticks(int'(RESET_RECOV_DEF) + 3, LVL_LOW);

        // first read slot at reset timing, then a shorter hold for the rest
        queue_beat(CMD_READ, 8'h00, 1'b1);
        queue_ticks(int'(READ_LOW_DEF) + int'(SLOT_HOLD_DEF) + int'(SLOT_RECOV_DEF),
                    LVL_RANDOM);
        drain();
        write_reg(REG_SLOT_HOLD, 1);
        queue_ticks(op_ticks(CMD_READ) + 2, LVL_RANDOM);

        // write with the reset slot start
        queue_op(CMD_WRITE, 8'hA5, LVL_HIGH);
        settle();

        // shortest timing: both reset outcomes, commands while busy, extreme bytes
        set_timing(1, 1, 1, 1, 1, 1, 1);
        queue_op(CMD_RESET, 8'h00, LVL_LOW);
        queue_op(CMD_RESET, 8'hFF, LVL_HIGH);
        queue_beat(CMD_WRITE, 8'hFF, 1'b1);
        queue_beat(CMD_RESET, 8'h00, 1'b0);
        queue_beat(CMD_READ, 8'h55, 1'b1);
        queue_beat(CMD_WRITE, 8'h00, 1'b0);
        queue_ticks(op_ticks(CMD_WRITE), LVL_RANDOM);
        queue_op(CMD_WRITE, 8'h00, LVL_LOW);
        queue_op(CMD_READ, 8'h00, LVL_HIGH);
        queue_op(CMD_READ, 8'hFF, LVL_LOW);
        settle();

        // longest timing: each operation holds its phase, then is cut short
        cut_long_op(CMD_RESET, 8'h00);
        cut_long_op(CMD_WRITE, 8'h5A);
        cut_long_op(CMD_READ, 8'h00);

        // random traffic under each idling pattern
        random_phase(0, 0);
        random_phase(72, 0);
        random_phase(0, 72);
        random_phase(18, 18);

        if (fail_count == 0 && bus_status_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
